@@ rtl/les_pkg.sv @@
// Shared types and constants for the link error statistics block.
// Used by les_front, les_back and link_error_stats_health; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

    // Default number of per-code error counters
    localparam int NUM_ERROR_CODES_DEF = 14;
    // Default depth of the queues between the stages
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Command codes
    localparam logic [2:0] CMD_SENT    = 3'd0;
    localparam logic [2:0] CMD_SUCCESS = 3'd1;
    localparam logic [2:0] CMD_ERROR   = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    // Health codes
    localparam logic [1:0] HS_OK    = 2'd0;
    localparam logic [1:0] HS_WARN  = 2'd1;
    localparam logic [1:0] HS_ALARM = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_WEIGHT = 2'd0;
    localparam logic [1:0] REG_WARN   = 2'd1;
    localparam logic [1:0] REG_ALARM  = 2'd2;

    localparam logic [15:0] WEIGHT_RST = 16'd5;
    localparam logic [15:0] WARN_RST   = 16'd10;
    localparam logic [15:0] ALARM_RST  = 16'd20;

    // Input request
    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] error_code;
        logic [4:0] counter_index;
    } t_in_item;

    // Result
    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  health_status;
        logic [15:0] error_level;
    } t_out_item;

    // Which counter a read returns
    typedef enum logic [2:0] {
        RD_NONE  = 3'd0,
        RD_CODE  = 3'd1,
        RD_TOTAL = 3'd2,
        RD_SUCC  = 3'd3,
        RD_ERRS  = 3'd4
    } t_rd_sel;

    // Decoded operation handed from front to back
    typedef struct packed {
        logic       clear;
        logic       bump_total;
        logic       success;
        logic       error;
        logic       code_hit;
        logic [3:0] code;
        t_rd_sel    rd_sel;
        logic [4:0] rd_code;
    } t_op;

    // Configuration values seen by the back end
    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] warn;
        logic [15:0] alarm;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/les_fifo.sv @@
// Small synchronous FIFO, generic in its payload type.
// Depends on nothing; used for the op queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module les_fifo #(
    parameter type t_data = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_data i_data,
    output logic  o_full,
    input  wire   i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/les_front.sv @@
// Front end: classifies an incoming request into a decoded op.
// Depends on les_pkg.
`timescale 1ns / 1ps
`default_nettype none

module les_front #(
    parameter int NUM_ERROR_CODES = les_pkg::NUM_ERROR_CODES_DEF
) (
    input  les_pkg::t_in_item i_item,
    output les_pkg::t_op      o_op
);

    logic [5:0] code_ext;
    logic [5:0] idx_ext;

    assign code_ext = {2'b00, i_item.error_code};
    assign idx_ext  = {1'b0, i_item.counter_index};

    // Command decode and range checks
    always_comb begin
        o_op          = '0;
        o_op.rd_sel   = les_pkg::RD_NONE;
        o_op.code     = i_item.error_code;
        o_op.rd_code  = i_item.counter_index;
        o_op.code_hit = (code_ext < 6'(NUM_ERROR_CODES));
        unique case (i_item.cmd)
            les_pkg::CMD_SENT:    o_op.bump_total = 1'b1;
            les_pkg::CMD_SUCCESS: o_op.success    = 1'b1;
            les_pkg::CMD_ERROR:   o_op.error      = 1'b1;
            les_pkg::CMD_CLEAR:   o_op.clear      = 1'b1;
            les_pkg::CMD_READ: begin
                priority if (idx_ext < 6'(NUM_ERROR_CODES)) begin
                    o_op.rd_sel = les_pkg::RD_CODE;
                end else if (idx_ext == 6'(NUM_ERROR_CODES)) begin
                    o_op.rd_sel = les_pkg::RD_TOTAL;
                end else if (idx_ext == 6'(NUM_ERROR_CODES + 1)) begin
                    o_op.rd_sel = les_pkg::RD_SUCC;
                end else if (idx_ext == 6'(NUM_ERROR_CODES + 2)) begin
                    o_op.rd_sel = les_pkg::RD_ERRS;
                end else begin
                    o_op.rd_sel = les_pkg::RD_NONE;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/les_back.sv @@
// Back end: counters, leaky error level and health status; executes one op per cycle
// into a result while the result side is ready. Depends on les_pkg.
`timescale 1ns / 1ps
`default_nettype none

module les_back #(
    parameter int NUM_ERROR_CODES = les_pkg::NUM_ERROR_CODES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  les_pkg::t_cfg      i_cfg,
    input  les_pkg::t_op       i_op,
    input  wire                i_op_valid,
    output logic               o_op_take,
    input  wire                i_res_ready,
    output les_pkg::t_out_item o_res,
    output logic               o_res_valid
);

    localparam int CW = (NUM_ERROR_CODES > 1) ? $clog2(NUM_ERROR_CODES) : 1;

    logic [31:0] r_code_cnt [NUM_ERROR_CODES];
    logic [31:0] r_total, r_succ, r_errs;
    logic [15:0] r_level, n_level;
    logic [1:0]  r_status, n_status;

    logic          exec;
    logic [16:0]   sum;
    logic [CW-1:0] wr_idx, rd_idx;
    logic [31:0]   rd_val;

    assign exec        = i_op_valid && i_res_ready;
    assign o_op_take   = exec;
    assign o_res_valid = exec;
    assign wr_idx      = CW'(i_op.code);
    assign rd_idx      = CW'(i_op.rd_code);
    assign sum         = {1'b0, r_level} + {1'b0, i_cfg.weight};

    // Next level and status
    always_comb begin
        n_level  = r_level;
        n_status = r_status;
        if (i_op.clear) begin
            n_level  = '0;
            n_status = les_pkg::HS_OK;
        end else if (i_op.success || i_op.error) begin
            if (i_op.error) begin
                n_level = sum[16] ? 16'hFFFF : sum[15:0];
            end else if (r_level != '0) begin
                n_level = r_level - 16'd1;
            end
            priority if (n_level < i_cfg.warn) begin
                n_status = les_pkg::HS_OK;
            end else if (n_level < i_cfg.alarm) begin
                n_status = les_pkg::HS_WARN;
            end else begin
                n_status = les_pkg::HS_ALARM;
            end
        end
    end

    // Counter read select
    always_comb begin
        unique case (i_op.rd_sel)
            les_pkg::RD_CODE:  rd_val = r_code_cnt[rd_idx];
            les_pkg::RD_TOTAL: rd_val = r_total;
            les_pkg::RD_SUCC:  rd_val = r_succ;
            les_pkg::RD_ERRS:  rd_val = r_errs;
            default:           rd_val = '0;
        endcase
    end

    always_comb begin
        o_res.read_data     = rd_val;
        o_res.health_status = n_status;
        o_res.error_level   = n_level;
    end

    // Statistic state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (exec && i_op.clear)) begin
            r_total  <= '0;
            r_succ   <= '0;
            r_errs   <= '0;
            r_level  <= '0;
            r_status <= les_pkg::HS_OK;
        end else if (exec) begin
            r_level  <= n_level;
            r_status <= n_status;
            if (i_op.bump_total) begin
                r_total <= r_total + 32'd1;
            end
            if (i_op.success) begin
                r_succ <= r_succ + 32'd1;
            end
            if (i_op.error) begin
                r_errs <= r_errs + 32'd1;
            end
        end
    end

    // Per-code counters
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_ERROR_CODES; i++) begin
            if (!i_rst_n || (exec && i_op.clear)) begin
                r_code_cnt[i] <= '0;
            end else if (exec && i_op.error && i_op.code_hit && wr_idx == CW'(i)) begin
                r_code_cnt[i] <= r_code_cnt[i] + 32'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/link_error_stats_health.sv @@
// Link error statistics with leaky-bucket health status.
// Channels: requests enter through push/full on i_item (cmd, error_code, counter_index);
// results leave through empty/pop on o_result (read_data, health_status, error_level),
// one result per request, in request order.
// A request passes through the op queue register, the back end and the result queue.
// Throughput: one request per cycle unless stalled; the back end executes one decoded op
// per cycle while the result queue has room, reading and updating the counters, level
// and status in a single step. A decoded op queue of QUEUE_DEPTH entries sits between
// decode and execution, and a result queue of QUEUE_DEPTH entries sits at the output.
// When the receiver stops popping, the result queue fills, execution holds, then the op
// queue fills and full rises; nothing is dropped.
// Reset (synchronous, i_rst_n low): queues empty, all counters, the level and the status
// clear, and the weight, warning limit and alarm limit return to 5/10/20.
// Configuration: APB registers at byte addresses 0 (weight), 4 (warning limit) and 8
// (alarm limit), 16 bits each; the user must write them only while the block is idle;
// the block does not enforce this. Depends on les_pkg, les_front, les_fifo and les_back.
`timescale 1ns / 1ps
`default_nettype none

module link_error_stats_health #(
    parameter int NUM_ERROR_CODES = les_pkg::NUM_ERROR_CODES_DEF,
    parameter int QUEUE_DEPTH     = les_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // request side
    input  wire                push,
    output logic               full,
    input  les_pkg::t_in_item  i_item,
    // result side
    output logic               empty,
    input  wire                pop,
    output les_pkg::t_out_item o_result,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    les_pkg::t_cfg      r_cfg;
    les_pkg::t_op       dec_op;
    les_pkg::t_op       head_op;
    les_pkg::t_out_item res;
    logic               op_empty, op_take;
    logic               res_full, res_valid;
    logic [1:0]         reg_idx;
    logic               cfg_wr;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight <= les_pkg::WEIGHT_RST;
            r_cfg.warn   <= les_pkg::WARN_RST;
            r_cfg.alarm  <= les_pkg::ALARM_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                les_pkg::REG_WEIGHT: r_cfg.weight <= pwdata[15:0];
                les_pkg::REG_WARN:   r_cfg.warn   <= pwdata[15:0];
                les_pkg::REG_ALARM:  r_cfg.alarm  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            les_pkg::REG_WEIGHT: prdata = {16'd0, r_cfg.weight};
            les_pkg::REG_WARN:   prdata = {16'd0, r_cfg.warn};
            les_pkg::REG_ALARM:  prdata = {16'd0, r_cfg.alarm};
            default:             prdata = '0;
        endcase
    end

    // Decode
    les_front #(
        .NUM_ERROR_CODES (NUM_ERROR_CODES)
    ) u_front (
        .i_item (i_item),
        .o_op   (dec_op)
    );

    // Decoded op queue
    les_fifo #(
        .t_data (les_pkg::t_op),
        .DEPTH  (QUEUE_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_op),
        .o_full  (full),
        .i_pop   (op_take),
        .o_data  (head_op),
        .o_empty (op_empty)
    );

    // Execute
    les_back #(
        .NUM_ERROR_CODES (NUM_ERROR_CODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op        (head_op),
        .i_op_valid  (!op_empty),
        .o_op_take   (op_take),
        .i_res_ready (!res_full),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    // Result queue
    les_fifo #(
        .t_data (les_pkg::t_out_item),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

@@ dv/link_error_stats_health_checker.sv @@
// Checker for link_error_stats_health: follows the request, result and APB channels,
// predicts each result from its own copy of the statistics, and counts mismatches.
// Depends on les_pkg for the item structs, command, health and register codes.
`timescale 1ns / 1ps

module link_error_stats_health_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // request channel
    input  wire                 i_push,
    input  wire                 i_full,
    input  les_pkg::t_in_item   i_item,
    // result channel
    input  wire                 i_empty,
    input  wire                 i_pop,
    input  les_pkg::t_out_item  i_result,
    // configuration port
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire [3:0]           i_paddr,
    input  wire [31:0]          i_pwdata,
    input  wire [31:0]          i_prdata,
    input  wire                 i_pready,
    // status toward the testbench top
    output int                  o_fail_count,
    output int                  o_waiting,
    output int                  o_checked
);

    localparam int N_CODES  = les_pkg::NUM_ERROR_CODES_DEF;
    localparam int IX_TOTAL = N_CODES;
    localparam int IX_SUCC  = N_CODES + 1;
    localparam int IX_ERRS  = N_CODES + 2;
    localparam int N_CTRS   = N_CODES + 3;

    // Shadow of the block's statistics and registers
    logic [31:0] event_cnt [N_CTRS];
    logic [15:0] leak_level;
    logic [1:0]  health;
    logic [15:0] cfg_weight;
    logic [15:0] cfg_warn;
    logic [15:0] cfg_alarm;

    // Predicted results, oldest first
    les_pkg::t_out_item health_q [$];

    int fails;
    int checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic clear_stats();
        for (int k = 0; k < N_CTRS; k++) begin
            event_cnt[k] = '0;
        end
        leak_level = '0;
        health     = les_pkg::HS_OK;
    endtask

    // Thresholds are tested in this order even when they are out of order
    function automatic logic [1:0] grade_level(input logic [15:0] lvl);
        if (lvl < cfg_warn) begin
            return les_pkg::HS_OK;
        end else if (lvl < cfg_alarm) begin
            return les_pkg::HS_WARN;
        end
        return les_pkg::HS_ALARM;
    endfunction

    // Apply one request to the shadow state and form its result
    task automatic apply_link_event(input les_pkg::t_in_item req,
                                    output les_pkg::t_out_item res);
        logic [16:0] sum;
        logic [31:0] rd;
        rd = '0;
        case (req.cmd)
            les_pkg::CMD_SENT: begin
                event_cnt[IX_TOTAL] += 32'd1;
            end
            les_pkg::CMD_SUCCESS: begin
                event_cnt[IX_SUCC] += 32'd1;
                if (leak_level != 16'd0) begin
                    leak_level -= 16'd1;
                end
                health = grade_level(leak_level);
            end
            les_pkg::CMD_ERROR: begin
                sum = {1'b0, leak_level} + {1'b0, cfg_weight};
                event_cnt[IX_ERRS] += 32'd1;
                // unknown codes still count as errors, but bump no per-code counter
                if (int'(req.error_code) < N_CODES) begin
                    event_cnt[req.error_code] += 32'd1;
                end
                leak_level = sum[16] ? 16'hFFFF : sum[15:0];
                health     = grade_level(leak_level);
            end
            les_pkg::CMD_READ: begin
                if (int'(req.counter_index) < N_CTRS) begin
                    rd = event_cnt[req.counter_index];
                end
            end
            les_pkg::CMD_CLEAR: begin
                clear_stats();
            end
            default: begin
                // unused commands change nothing
            end
        endcase
        res.read_data     = rd;
        res.health_status = health;
        res.error_level   = leak_level;
    endtask

    function automatic logic [15:0] reg_value(input logic [1:0] idx);
        case (idx)
            les_pkg::REG_WEIGHT: return cfg_weight;
            les_pkg::REG_WARN:   return cfg_warn;
            default:             return cfg_alarm;
        endcase
    endfunction

    // Sample every channel at the rising edge
    always @(posedge i_clk) begin
        les_pkg::t_out_item want;
        les_pkg::t_out_item pred;
        if (!i_rst_n) begin
            clear_stats();
            cfg_weight = les_pkg::WEIGHT_RST;
            cfg_warn   = les_pkg::WARN_RST;
            cfg_alarm  = les_pkg::ALARM_RST;
            health_q.delete();
        end else begin
            // register writes and read-back
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        les_pkg::REG_WEIGHT: cfg_weight = i_pwdata[15:0];
                        les_pkg::REG_WARN:   cfg_warn   = i_pwdata[15:0];
                        les_pkg::REG_ALARM:  cfg_alarm  = i_pwdata[15:0];
                        default: ;
                    endcase
                end else if (i_paddr[3:2] != 2'd3) begin
                    if (i_prdata !== {16'h0, reg_value(i_paddr[3:2])}) begin
                        report_mismatch("register read-back", i_prdata,
                                        {16'h0, reg_value(i_paddr[3:2])});
                    end
                end
            end
            // result side first: an accepted result belongs to an older request
            if (i_pop && !i_empty) begin
                if (health_q.size() == 0) begin
                    report_mismatch("result with no request waiting", i_result.read_data,
                                    32'h0);
                end else begin
                    want = health_q.pop_front();
                    checked++;
                    if (i_result.read_data !== want.read_data) begin
                        report_mismatch("read_data", i_result.read_data, want.read_data);
                    end
                    if (i_result.health_status !== want.health_status) begin
                        report_mismatch("health_status", {30'h0, i_result.health_status},
                                        {30'h0, want.health_status});
                    end
                    if (i_result.error_level !== want.error_level) begin
                        report_mismatch("error_level", {16'h0, i_result.error_level},
                                        {16'h0, want.error_level});
                    end
                end
            end
            // request side
            if (i_push && !i_full) begin
                apply_link_event(i_item, pred);
                health_q.push_back(pred);
            end
        end
        o_fail_count <= fails;
        o_waiting    <= health_q.size();
        o_checked    <= checked;
    end

endmodule

@@ dv/link_error_stats_health_tb.sv @@
// Testbench top for link_error_stats_health: clock, reset, request and pop traffic,
// APB register settings, and the final verdict.
// Depends on les_pkg, the block, and link_error_stats_health_checker.
`timescale 1ns / 1ps

module link_error_stats_health_tb;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    les_pkg::t_in_item  i_item  = '0;
    logic               empty;
    logic               pop     = 1'b0;
    les_pkg::t_out_item o_result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [3:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          fail_count;
    int          waiting;
    int          checked;
    int          n_requests = 0;
    int          n_settings = 0;
    // no idling on either side while set
    logic        steady = 1'b0;

    always #2 i_clk = ~i_clk;

    link_error_stats_health u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    link_error_stats_health_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    // Receiver: stalls about a third of the cycles unless steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= steady ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    function automatic les_pkg::t_in_item mk_req(input logic [2:0] cmd,
                                                 input logic [3:0] code,
                                                 input logic [4:0] idx);
        les_pkg::t_in_item req;
        req.cmd           = cmd;
        req.error_code    = code;
        req.counter_index = idx;
        return req;
    endfunction

    // Mostly legal commands; some unused commands, unknown codes and bad indexes
    function automatic les_pkg::t_in_item random_request();
        les_pkg::t_in_item req;
        int                r;
        r = $urandom_range(99);
        if (r < 20) begin
            req.cmd = les_pkg::CMD_SENT;
        end else if (r < 45) begin
            req.cmd = les_pkg::CMD_SUCCESS;
        end else if (r < 75) begin
            req.cmd = les_pkg::CMD_ERROR;
        end else if (r < 92) begin
            req.cmd = les_pkg::CMD_READ;
        end else if (r < 94) begin
            req.cmd = les_pkg::CMD_CLEAR;
        end else begin
            req.cmd = 3'($urandom_range(7, 5));
        end
        if ($urandom_range(99) < 90) begin
            req.error_code = 4'($urandom_range(les_pkg::NUM_ERROR_CODES_DEF - 1));
        end else begin
            req.error_code = 4'($urandom_range(15, les_pkg::NUM_ERROR_CODES_DEF));
        end
        if ($urandom_range(99) < 85) begin
            req.counter_index = 5'($urandom_range(les_pkg::NUM_ERROR_CODES_DEF + 2));
        end else begin
            req.counter_index = 5'($urandom_range(31, les_pkg::NUM_ERROR_CODES_DEF + 3));
        end
        return req;
    endfunction

    // Offer one request after random idle cycles, and hold it until taken
    task automatic send_request(input les_pkg::t_in_item req);
        // each cycle idles with a one-in-three chance unless steady
        if (!steady) begin
            while ($urandom_range(99) < 33) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push   <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_requests++;
    endtask

    // Stop offering and wait until every predicted result has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    // APB transfer: setup, access, then return to idle
    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] weight, input logic [15:0] warn,
                             input logic [15:0] alarm);
        apb_xfer(1'b1, les_pkg::REG_WEIGHT, weight);
        apb_xfer(1'b1, les_pkg::REG_WARN, warn);
        apb_xfer(1'b1, les_pkg::REG_ALARM, alarm);
        apb_xfer(1'b0, les_pkg::REG_WEIGHT, 16'h0);
        apb_xfer(1'b0, les_pkg::REG_WARN, 16'h0);
        apb_xfer(1'b0, les_pkg::REG_ALARM, 16'h0);
        n_settings++;
    endtask

    task automatic random_phase(input logic [15:0] weight, input logic [15:0] warn,
                                input logic [15:0] alarm, input int count,
                                input logic no_idle);
        drain();
        configure(weight, warn, alarm);
        steady <= no_idle;
        repeat (count) send_request(random_request());
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset settings
        send_request(mk_req(les_pkg::CMD_SENT, 4'd0, 5'd0));
        send_request(mk_req(les_pkg::CMD_SUCCESS, 4'd0, 5'd0));    // leak at level zero
        send_request(mk_req(les_pkg::CMD_ERROR, 4'd0, 5'd0));
        send_request(mk_req(les_pkg::CMD_ERROR, 4'd13, 5'd0));
        send_request(mk_req(les_pkg::CMD_ERROR, 4'd14, 5'd0));     // unknown codes
        send_request(mk_req(les_pkg::CMD_ERROR, 4'd15, 5'd31));    // level reaches alarm
        send_request(mk_req(les_pkg::CMD_SUCCESS, 4'd15, 5'd31));  // back to warning
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd0));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd13));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd14));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd15));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd16));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd17));      // past the last counter
        send_request(mk_req(les_pkg::CMD_READ, 4'd15, 5'd31));
        send_request(mk_req(3'd5, 4'd2, 5'd1));                    // unused commands
        send_request(mk_req(3'd6, 4'd0, 5'd0));
        send_request(mk_req(3'd7, 4'd15, 5'd31));
        send_request(mk_req(les_pkg::CMD_CLEAR, 4'd0, 5'd0));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd16));
        send_request(mk_req(les_pkg::CMD_ERROR, 4'd7, 5'd0));
        send_request(mk_req(les_pkg::CMD_READ, 4'd0, 5'd7));

        // random requests under a series of register settings
        random_phase(16'd5, 16'd10, 16'd20, 100, 1'b0);
        random_phase(16'd0, 16'd0, 16'd0, 80, 1'b0);
        random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b1);   // saturation
        random_phase(16'd37, 16'd300, 16'd100, 100, 1'b0);       // thresholds swapped
        random_phase(16'd1, 16'd3, 16'd6, 100, 1'b0);
        random_phase(16'($urandom_range(40)), 16'($urandom_range(200)),
                     16'($urandom_range(400)), 120, 1'b0);

        drain();
        steady <= 1'b0;
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests, directed and random, under %0d register settings.",
                 n_requests, n_settings);
        $display("Compared %0d results field by field; %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && waiting == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #500000;
        $display("Run timed out with %0d results still waiting", waiting);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
